FILE: hdl/tmtw_pkg.sv
// Shared types, constants and codes for the text mode terminal writer.
`timescale 1ns / 1ps

package tmtw_pkg;

    // Screen geometry.
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int COPY_COUNT = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int COL_W      = $clog2(COLUMNS);

    // Character codes.
    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [7:0] PRINT_LOW    = 8'h20;
    localparam logic [7:0] PRINT_HIGH   = 8'h7F;

    // Configuration register file.
    localparam int         PADDR_W         = 3;
    localparam logic       REG_TEXT_COLOUR = 1'b0;
    localparam logic [7:0] COLOUR_RESET    = 8'h07;

    // Request action codes.
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // Input request and result payloads.
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_column;
    } in_item_t;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [4:0]  cursor_row_now;
        logic [6:0]  cursor_column_now;
    } out_item_t;

    // How the memory port is driven by the sweep counter.
    typedef enum logic [1:0] {
        SW_IDLE,
        SW_ZERO,
        SW_COPY,
        SW_FILL
    } sweep_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic   accept;
        logic   cnt_clear;
        logic   cnt_inc;
        sweep_t sweep;
        logic   cell_from_mem;
        logic   res_to_out;
        logic   res_to_pend;
        logic   pend_to_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] action;
        logic       scroll_needed;
        logic       copy_end;
        logic       sweep_end;
    } sts_t;

endpackage

FILE: hdl/text_mode_terminal_writer.sv
// Top level of the text mode terminal writer: configuration port, controller and datapath.
`timescale 1ns / 1ps

// A text screen of ROWS x COLUMNS (25 x 80) 16-bit cells, colour in the high byte and
// character in the low byte, with a cursor. After reset the block runs a clearing pass
// through the screen memory and takes no request meanwhile; configuration writes are
// taken at any time. A character write, a newline, an ignored byte or the unused action
// is finished in the idle state that accepts it; a read goes on to the read state for the
// registered memory read. A clear blanks every cell, and a write or newline that scrolls
// moves the lower rows up one row and blanks the last: both are paced by the single write
// port of the screen memory, which moves or fills one cell per cycle. Every request gives
// one result; a result register and one pending slot let the next request be taken while
// a result waits on a stalled output.
module text_mode_terminal_writer import tmtw_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_payload,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [7:0] text_colour_reg, text_colour_next;
    logic       reg_index;
    logic       cfg_write;
    cmd_t       cmd;
    sts_t       sts;

    // Register decode on the configuration port.
    assign pready    = 1'b1;
    assign reg_index = paddr[PADDR_W-1];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        text_colour_next = text_colour_reg;
        if (cfg_write && (reg_index == REG_TEXT_COLOUR)) begin
            text_colour_next = pwdata[7:0];
        end
        prdata = (reg_index == REG_TEXT_COLOUR) ? {24'h000000, text_colour_reg} : 32'h0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_colour_reg <= COLOUR_RESET;
        end else begin
            text_colour_reg <= text_colour_next;
        end
    end

    tmtw_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    tmtw_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_item    (s_payload),
        .text_colour(text_colour_reg),
        .out_item   (m_payload)
    );

endmodule

FILE: hdl/tmtw_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module tmtw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/tmtw_dpath.sv
// Datapath of the terminal writer: cursor, sweep counter, screen store and result registers.
`timescale 1ns / 1ps

module tmtw_dpath import tmtw_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cmd_t      cmd,
    output sts_t      sts,
    input  in_item_t  in_item,
    input  logic [7:0] text_colour,
    output out_item_t out_item
);

    logic [ROW_W-1:0]  cursor_row_reg, cursor_row_next;
    logic [COL_W-1:0]  cursor_column_reg, cursor_column_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic              rd_ok_reg, rd_ok_next;
    out_item_t         out_reg, out_next;
    out_item_t         pend_reg, pend_next;
    out_item_t         res;

    logic              is_print;
    logic              is_newline;
    logic              wrap;
    logic              last_row;
    logic              rd_in_range;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] rd_addr;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [15:0]       mem_rdata;

    // Fit the cursor into the 5-bit and 7-bit result fields.
    function automatic logic [4:0] fit_row(input logic [ROW_W-1:0] r);
        logic [31:0] wide;
        wide = 32'(r);
        return wide[4:0];
    endfunction

    function automatic logic [6:0] fit_col(input logic [COL_W-1:0] c);
        logic [31:0] wide;
        wide = 32'(c);
        return wide[6:0];
    endfunction

    // Decode the incoming request and the cursor position.
    assign is_print    = in_item.char_code inside {[PRINT_LOW:PRINT_HIGH]};
    assign is_newline  = in_item.char_code == NEWLINE_CHAR;
    assign wrap        = cursor_column_reg == COL_W'(COLUMNS - 1);
    assign last_row    = cursor_row_reg == ROW_W'(ROWS - 1);
    assign rd_in_range = (int'(in_item.read_row) < ROWS) && (int'(in_item.read_column) < COLUMNS);
    assign cur_addr    = ADDR_W'(int'(cursor_row_reg) * COLUMNS + int'(cursor_column_reg));
    assign rd_addr     = ADDR_W'(int'(in_item.read_row) * COLUMNS + int'(in_item.read_column));

    // Status toward the controller.
    always_comb begin
        sts.action        = in_item.action;
        sts.scroll_needed = (in_item.action == ACT_WRITE) && last_row
                            && ((is_print && wrap) || is_newline);
        sts.copy_end      = cnt_reg == ADDR_W'(COPY_COUNT);
        sts.sweep_end     = cnt_reg == ADDR_W'(CELL_COUNT - 1);
    end

    // Cursor update when a request is taken.
    always_comb begin
        cursor_row_next    = cursor_row_reg;
        cursor_column_next = cursor_column_reg;
        if (cmd.accept) begin
            case (in_item.action)
                ACT_WRITE: begin
                    if ((is_print && wrap) || is_newline) begin
                        cursor_column_next = '0;
                        if (!last_row) begin
                            cursor_row_next = cursor_row_reg + ROW_W'(1);
                        end
                    end else if (is_print) begin
                        cursor_column_next = cursor_column_reg + COL_W'(1);
                    end
                end
                ACT_CLEAR: begin
                    cursor_row_next    = '0;
                    cursor_column_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Memory port: single writes on request, otherwise driven by the sweep counter.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cur_addr;
        mem_wdata = {text_colour, in_item.char_code};
        mem_re    = 1'b0;
        mem_raddr = rd_addr;
        case (cmd.sweep)
            SW_ZERO: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = '0;
            end
            SW_COPY: begin
                // Read one row ahead and write the cell read in the previous cycle.
                mem_we    = cnt_reg != '0;
                mem_waddr = cnt_reg - ADDR_W'(1);
                mem_wdata = mem_rdata;
                mem_re    = !sts.copy_end;
                mem_raddr = cnt_reg + ADDR_W'(COLUMNS);
            end
            SW_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = {text_colour, BLANK_CHAR};
            end
            default: begin
                if (cmd.accept) begin
                    mem_we = (in_item.action == ACT_WRITE) && is_print;
                    mem_re = (in_item.action == ACT_READ) && rd_in_range;
                end
            end
        endcase
    end

    tmtw_ram #(
        .WIDTH(16),
        .DEPTH(CELL_COUNT)
    ) u_screen (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    // Result assembly and the output and pending slots.
    always_comb begin
        res.cell_value        = (cmd.cell_from_mem && rd_ok_reg) ? mem_rdata : 16'h0000;
        res.cursor_row_now    = fit_row(cursor_row_next);
        res.cursor_column_now = fit_col(cursor_column_next);

        rd_ok_next = cmd.accept ? rd_in_range : rd_ok_reg;

        cnt_next = cnt_reg;
        if (cmd.cnt_clear) begin
            cnt_next = '0;
        end else if (cmd.cnt_inc) begin
            cnt_next = cnt_reg + ADDR_W'(1);
        end

        out_next = out_reg;
        if (cmd.pend_to_out) begin
            out_next = pend_reg;
        end else if (cmd.res_to_out) begin
            out_next = res;
        end
        pend_next = cmd.res_to_pend ? res : pend_reg;
    end

    assign out_item = out_reg;

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_row_reg    <= '0;
            cursor_column_reg <= '0;
            cnt_reg           <= '0;
        end else begin
            cursor_row_reg    <= cursor_row_next;
            cursor_column_reg <= cursor_column_next;
            cnt_reg           <= cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        rd_ok_reg <= rd_ok_next;
        out_reg   <= out_next;
        pend_reg  <= pend_next;
    end

`ifndef SYNTHESIS
    a_copy_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.sweep == SW_COPY) |-> (cnt_reg <= ADDR_W'(COPY_COUNT)))
        else $error("copy sweep ran past the last moved cell");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (int'(cursor_row_reg) < ROWS) && (int'(cursor_column_reg) < COLUMNS))
        else $error("cursor left the screen");

    a_no_write_on_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && (in_item.action == ACT_READ)) |-> !mem_we)
        else $error("read request wrote the screen store");
`endif

endmodule

FILE: hdl/tmtw_ctrl.sv
// Controller state machine of the terminal writer: sequencing, sweeps and result slots.
`timescale 1ns / 1ps

module tmtw_ctrl import tmtw_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_BLANK,
        ST_CLEAR
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   pend_valid_reg, pend_valid_next;
    logic   accept;
    logic   produce;
    logic   out_free;

    assign s_ready = (state_reg == ST_IDLE) && !pend_valid_reg;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    // Sequencing of requests and memory sweeps.
    always_comb begin
        state_next        = state_reg;
        produce           = 1'b0;
        cmd.accept        = 1'b0;
        cmd.cnt_clear     = 1'b0;
        cmd.cnt_inc       = 1'b0;
        cmd.sweep         = SW_IDLE;
        cmd.cell_from_mem = 1'b0;
        case (state_reg)
            ST_INIT: begin
                cmd.sweep   = SW_ZERO;
                cmd.cnt_inc = 1'b1;
                if (sts.sweep_end) begin
                    cmd.cnt_clear = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_IDLE: begin
                cmd.cnt_clear = 1'b1;
                if (accept) begin
                    cmd.accept = 1'b1;
                    case (sts.action)
                        ACT_WRITE: begin
                            if (sts.scroll_needed) begin
                                state_next = ST_COPY;
                            end else begin
                                produce = 1'b1;
                            end
                        end
                        ACT_CLEAR: state_next = ST_CLEAR;
                        ACT_READ:  state_next = ST_READ;
                        default:   produce    = 1'b1;
                    endcase
                end
            end
            ST_READ: begin
                cmd.cell_from_mem = 1'b1;
                produce           = 1'b1;
                state_next        = ST_IDLE;
            end
            ST_COPY: begin
                cmd.sweep = SW_COPY;
                if (sts.copy_end) begin
                    state_next = ST_BLANK;
                end else begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            ST_BLANK, ST_CLEAR: begin
                cmd.sweep   = SW_FILL;
                cmd.cnt_inc = 1'b1;
                if (sts.sweep_end) begin
                    cmd.cnt_clear = 1'b1;
                    produce       = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Routing of a finished result into the output register or the pending slot.
        out_free        = !m_valid_reg || m_ready;
        cmd.pend_to_out = out_free && pend_valid_reg;
        cmd.res_to_out  = produce && out_free && !pend_valid_reg;
        cmd.res_to_pend = produce && (!out_free || pend_valid_reg);
        m_valid_next    = out_free ? (pend_valid_reg || produce) : 1'b1;
        if (pend_valid_reg) begin
            pend_valid_next = out_free ? produce : 1'b1;
        end else begin
            pend_valid_next = produce && !out_free;
        end
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_INIT;
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_pend_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> m_valid_reg)
        else $error("pending result held while the output register is empty");

    a_no_pend_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_to_pend |-> (!pend_valid_reg || cmd.pend_to_out))
        else $error("pending result overwritten before delivery");

    a_read_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (sts.action == ACT_READ)) |=> (state_reg == ST_READ))
        else $error("read request did not enter the read wait state");
`endif

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the text mode terminal writer.
`timescale 1ns / 1ps

module tb;
    import tmtw_pkg::*;

    // The unused action code has no name in the package.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [PADDR_W-1:0] COLOUR_ADDR = PADDR_W'({REG_TEXT_COLOUR, 2'b00});
    localparam int PHASES          = 5;
    localparam int ITEMS_PER_PHASE = 220;
    localparam int SETTLE_CYCLES   = 2100;
    localparam int LONG_HOLD       = 400;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    in_item_t           s_payload;
    logic               m_valid;
    logic               m_ready;
    out_item_t          m_payload;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    text_mode_terminal_writer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Clock with a 12 ns period.
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Shadow copy of the screen, cursor and colour.
    logic [15:0] shadow_screen [CELL_COUNT];
    int          shadow_row;
    int          shadow_col;
    logic [7:0]  shadow_colour;

    // Results still owed by the block, oldest first.
    out_item_t expected_outputs [$];

    int error_count;
    int results_checked;
    int requests_sent;
    int read_count;
    int clear_count;
    int scroll_count;
    int colours_used;

    // Idle pattern state of each side, and the long hold-off handshake.
    int send_stretch_left;
    bit send_no_idle;
    int recv_stretch_left;
    bit recv_no_idle;
    bit long_hold_req;

    // One row of the directed table: a request, how often it repeats, and
    // optionally a result typed in by hand.
    typedef struct {
        in_item_t  req;
        int        copies;
        bit        typed;
        out_item_t result;
    } stim_row_t;

    stim_row_t directed_rows [$];

    // Moves the cursor to the start of the next row, scrolling on the last row.
    function void advance_row();
        int i;
        shadow_col = 0;
        shadow_row++;
        if (shadow_row >= ROWS) begin
            for (i = 0; i < COPY_COUNT; i++) begin
                shadow_screen[i] = shadow_screen[i + COLUMNS];
            end
            for (i = COPY_COUNT; i < CELL_COUNT; i++) begin
                shadow_screen[i] = {shadow_colour, BLANK_CHAR};
            end
            shadow_row = ROWS - 1;
            scroll_count++;
        end
    endfunction

    // Applies one request to the shadow state and returns the result it gives.
    function automatic out_item_t predict_terminal_result(input in_item_t req);
        out_item_t res;
        int        i;
        res = '0;
        case (req.action)
            ACT_WRITE: begin
                if (req.char_code >= PRINT_LOW && req.char_code <= PRINT_HIGH) begin
                    shadow_screen[shadow_row * COLUMNS + shadow_col] =
                        {shadow_colour, req.char_code};
                    shadow_col++;
                    if (shadow_col >= COLUMNS) advance_row();
                end else if (req.char_code == NEWLINE_CHAR) begin
                    advance_row();
                end
            end
            ACT_CLEAR: begin
                for (i = 0; i < CELL_COUNT; i++) begin
                    shadow_screen[i] = {shadow_colour, BLANK_CHAR};
                end
                shadow_row = 0;
                shadow_col = 0;
                clear_count++;
            end
            ACT_READ: begin
                read_count++;
                if (req.read_row < ROWS && req.read_column < COLUMNS) begin
                    res.cell_value = shadow_screen[req.read_row * COLUMNS + req.read_column];
                end
            end
            default: ;
        endcase
        res.cursor_row_now    = 5'(shadow_row);
        res.cursor_column_now = 7'(shadow_col);
        return res;
    endfunction

    // Cycles to wait before the next request or result, with stretches of no idling.
    function automatic int draw_gap(ref int stretch_left, ref bit no_idle);
        if (stretch_left == 0) begin
            stretch_left = $urandom_range(60, 20);
            no_idle      = ($urandom_range(3, 0) == 0);
        end
        stretch_left--;
        return no_idle ? 0 : $urandom_range(14, 0);
    endfunction

    // Random request: mostly text and newlines, with reads at in-range cells, on the cursor row and anywhere.
    function automatic in_item_t draw_request();
        in_item_t req;
        int       pick;
        req.action      = 2'($urandom);
        req.char_code   = 8'($urandom);
        req.read_row    = 5'($urandom);
        req.read_column = 7'($urandom);
        pick = $urandom_range(99, 0);
        if (pick < 55) begin
            req.action    = ACT_WRITE;
            req.char_code = 8'($urandom_range(PRINT_HIGH, PRINT_LOW));
        end else if (pick < 59) begin
            req.action    = ACT_WRITE;
            req.char_code = NEWLINE_CHAR;
        end else if (pick < 65) begin
            // Control bytes and bytes above the printable range.
            req.action = ACT_WRITE;
            if ($urandom_range(1, 0) == 1) begin
                req.char_code = 8'($urandom_range(8'h1F, 8'h00));
            end else begin
                req.char_code = 8'($urandom_range(8'hFF, 8'h80));
            end
        end else if (pick < 80) begin
            req.action      = ACT_READ;
            req.read_row    = 5'($urandom_range(ROWS - 1, 0));
            req.read_column = 7'($urandom_range(COLUMNS - 1, 0));
        end else if (pick < 87) begin
            req.action      = ACT_READ;
            req.read_row    = 5'(shadow_row);
            req.read_column = 7'($urandom_range(COLUMNS - 1, 0));
        end else if (pick < 94) begin
            req.action = ACT_READ;
        end else if (pick < 95) begin
            req.action = ACT_CLEAR;
        end else begin
            req.action = ACT_UNUSED;
        end
        return req;
    endfunction

    function void add_row(input logic [1:0] act, input logic [7:0] ch,
                          input logic [4:0] rr, input logic [6:0] rc, input int copies,
                          input bit typed, input logic [15:0] cell_word,
                          input logic [4:0] crow, input logic [6:0] ccol);
        stim_row_t r;
        r.req    = '{action: act, char_code: ch, read_row: rr, read_column: rc};
        r.copies = copies;
        r.typed  = typed;
        r.result = '{cell_value: cell_word, cursor_row_now: crow, cursor_column_now: ccol};
        directed_rows.push_back(r);
    endfunction

    // Offers one request after a random gap and records the result it should give.
    task automatic offer_request(input in_item_t req, input bit typed,
                                 input out_item_t typed_result);
        int        gap;
        out_item_t predicted;
        gap = draw_gap(send_stretch_left, send_no_idle);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= req;
        @(posedge aclk);
        while (!(s_valid && s_ready)) @(posedge aclk);
        predicted = predict_terminal_result(req);
        expected_outputs.push_back(typed ? typed_result : predicted);
        requests_sent++;
    endtask

    task drop_valid();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task wait_for_results();
        while (expected_outputs.size() != 0) @(negedge aclk);
    endtask

    // Writes the colour register over the APB port, then reads it back.
    task automatic set_text_colour(input logic [7:0] colour);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= COLOUR_ADDR;
        pwdata  <= {24'd0, colour};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!(psel && penable && pwrite && pready)) @(posedge aclk);
        shadow_colour = colour;
        colours_used++;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!(psel && penable && pready)) @(posedge aclk);
        if (prdata[7:0] !== colour) begin
            error_count++;
            if (error_count <= 10) begin
                $display("colour read back: expected %h, got %h", colour, prdata[7:0]);
            end
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result checker: every accepted result is compared with the oldest expectation.
    always @(posedge aclk) begin : check_results
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_outputs.size() == 0) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("%0t: result with nothing expected: cell %h row %0d col %0d",
                             $realtime, m_payload.cell_value, m_payload.cursor_row_now,
                             m_payload.cursor_column_now);
                end
            end else begin
                want = expected_outputs.pop_front();
                results_checked++;
                if (m_payload.cell_value !== want.cell_value ||
                    m_payload.cursor_row_now !== want.cursor_row_now ||
                    m_payload.cursor_column_now !== want.cursor_column_now) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("%0t: mismatch: cell %h/%h row %0d/%0d col %0d/%0d",
                                 $realtime, want.cell_value, m_payload.cell_value,
                                 want.cursor_row_now, m_payload.cursor_row_now,
                                 want.cursor_column_now, m_payload.cursor_column_now);
                    end
                end
            end
        end
    end

    // Result receiver: random stalls, plus one long hold-off on request.
    initial begin : receive_results
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end
            stall = draw_gap(recv_stretch_left, recv_no_idle);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
        end
    end

    // Main stimulus: reset, directed table, then random phases at several colours.
    initial begin : stimulus
        logic [7:0] phase_colours [PHASES];
        int         p;
        int         n;
        int         k;
        s_valid   = 1'b0;
        s_payload = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        aresetn   = 1'b0;
        error_count   = 0;
        long_hold_req = 1'b0;
        shadow_row    = 0;
        shadow_col    = 0;
        shadow_colour = COLOUR_RESET;
        for (n = 0; n < CELL_COUNT; n++) shadow_screen[n] = '0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reads after reset, out-of-range reads and the unused action.
        add_row(ACT_READ,   8'h00,        5'd0,  7'd0,   1, 1'b1, 16'h0000, 5'd0, 7'd0);
        add_row(ACT_READ,   8'h00,        5'd24, 7'd79,  1, 1'b1, 16'h0000, 5'd0, 7'd0);
        add_row(ACT_READ,   8'hFF,        5'd31, 7'd127, 1, 1'b1, 16'h0000, 5'd0, 7'd0);
        add_row(ACT_UNUSED, 8'hFF,        5'd31, 7'd127, 1, 1'b1, 16'h0000, 5'd0, 7'd0);
        // Printable limits, ignored bytes and a newline.
        add_row(ACT_WRITE,  8'h41,        5'd0,  7'd0,   1, 1'b0, 16'h0000, 5'd0, 7'd0);
        add_row(ACT_WRITE,  PRINT_LOW,    5'd0,  7'd0,   1, 1'b0, 16'h0000, 5'd0, 7'd0);
        add_row(ACT_WRITE,  PRINT_HIGH,   5'd0,  7'd0,   1, 1'b0, 16'h0000, 5'd0, 7'd0);
        add_row(ACT_WRITE,  8'h80,        5'd0,  7'd0,   1, 1'b0, 16'h0000, 5'd0, 7'd0);
        add_row(ACT_WRITE,  8'hFF,        5'd0,  7'd0,   1, 1'b0, 16'h0000, 5'd0, 7'd0);
        add_row(ACT_WRITE,  8'h00,        5'd0,  7'd0,   1, 1'b0, 16'h0000, 5'd0, 7'd0);
        add_row(ACT_WRITE,  NEWLINE_CHAR, 5'd0,  7'd0,   1, 1'b0, 16'h0000, 5'd0, 7'd0);
        add_row(ACT_READ,   8'h00,        5'd0,  7'd0,   1, 1'b1, 16'h0741, 5'd1, 7'd0);
        add_row(ACT_READ,   8'h00,        5'd0,  7'd2,   1, 1'b1, 16'h077F, 5'd1, 7'd0);
        add_row(ACT_READ,   8'h00,        5'd0,  7'd80,  1, 1'b1, 16'h0000, 5'd1, 7'd0);
        add_row(ACT_READ,   8'h00,        5'd25, 7'd0,   1, 1'b1, 16'h0000, 5'd1, 7'd0);
        // Clear, then fill to the last row and scroll by newline and by wrapping.
        add_row(ACT_CLEAR,  8'h00,        5'd0,  7'd0,   1, 1'b1, 16'h0000, 5'd0, 7'd0);
        add_row(ACT_READ,   8'h00,        5'd24, 7'd79,  1, 1'b1, 16'h0720, 5'd0, 7'd0);
        add_row(ACT_WRITE,  NEWLINE_CHAR, 5'd0,  7'd0,  24, 1'b0, 16'h0000, 5'd0, 7'd0);
        add_row(ACT_WRITE,  8'h5A,        5'd0,  7'd0,  79, 1'b0, 16'h0000, 5'd0, 7'd0);
        add_row(ACT_WRITE,  NEWLINE_CHAR, 5'd0,  7'd0,   1, 1'b1, 16'h0000, 5'd24, 7'd0);
        add_row(ACT_READ,   8'h00,        5'd23, 7'd0,   1, 1'b1, 16'h075A, 5'd24, 7'd0);
        add_row(ACT_READ,   8'h00,        5'd24, 7'd0,   1, 1'b1, 16'h0720, 5'd24, 7'd0);
        add_row(ACT_WRITE,  8'h21,        5'd0,  7'd0,  80, 1'b0, 16'h0000, 5'd0, 7'd0);
        add_row(ACT_READ,   8'h00,        5'd23, 7'd79,  1, 1'b1, 16'h0721, 5'd24, 7'd0);

        foreach (directed_rows[i]) begin
            for (k = 0; k < directed_rows[i].copies; k++) begin
                offer_request(directed_rows[i].req, directed_rows[i].typed,
                              directed_rows[i].result);
            end
        end

        phase_colours[0] = 8'hFF;
        phase_colours[1] = 8'h00;
        phase_colours[2] = 8'h1E;
        phase_colours[3] = 8'($urandom);
        phase_colours[4] = COLOUR_RESET;

        for (p = 0; p < PHASES; p++) begin
            // The colour only changes once the block has gone quiet.
            drop_valid();
            wait_for_results();
            repeat (SETTLE_CYCLES) @(negedge aclk);
            set_text_colour(phase_colours[p]);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == 1 && n == 100) long_hold_req = 1'b1;
                if (p == 2 && n == 120) begin
                    drop_valid();
                    wait_for_results();
                end
                offer_request(draw_request(), 1'b0, '0);
            end
        end

        drop_valid();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("Sent %0d requests: %0d reads, %0d clears, %0d scrolls, %0d colours.",
                 requests_sent, read_count, clear_count, scroll_count, colours_used);
        $display("Checked %0d results, %0d errors.", results_checked, error_count);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Run limit, well above the slowest expected run.
    initial begin : run_limit
        #12_000_000;
        $display("Run limit reached with %0d results outstanding.", expected_outputs.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
